### sv/npv_pkg.sv
// ----------------------------------------------------------------------------
// npv_pkg: shared types and constants
// Widths, status codes, result word and shared-adder request for the NPV block.
// ----------------------------------------------------------------------------
package npv_pkg;

    localparam int CASH_W = 48;
    localparam int RATE_W = 32;
    localparam int SUM_W  = 64;
    localparam int ERR_W  = 4;
    localparam int STAT_W = 2;
    localparam int FRAC_W = 24;
    localparam int ALU_W  = SUM_W + 1;
    localparam int DVD_W  = CASH_W + FRAC_W;
    localparam int PROD_W = SUM_W + RATE_W;
    localparam int CNT_W  = 7;

    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DVD_W - 1);
    localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(RATE_W - 1);

    localparam logic [RATE_W:0] Q24_ONE = (RATE_W + 1)'(1) << FRAC_W;

    localparam logic [STAT_W-1:0] ST_OK          = 2'd0;
    localparam logic [STAT_W-1:0] ST_INPUT_ERR   = 2'd1;
    localparam logic [STAT_W-1:0] ST_NUMERIC_ERR = 2'd2;

    typedef struct packed {
        logic signed [SUM_W-1:0] npv;
        logic [STAT_W-1:0]       status;
        logic [ERR_W-1:0]        error_out;
    } t_npv_res;

    typedef struct packed {
        logic [ALU_W-1:0] a;
        logic [ALU_W-1:0] b;
        logic             sub;
    } t_alu_req;

endpackage

### sv/npv_in_if.sv
// ----------------------------------------------------------------------------
// npv_in_if: cash flow channel
// Valid/ready channel carrying one cash flow word.
// ----------------------------------------------------------------------------
interface npv_in_if;
    import npv_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [CASH_W-1:0] cash;
    logic                     skip;
    logic [ERR_W-1:0]         error_in;
    logic                     last;

    modport source (output valid, cash, skip, error_in, last, input ready);
    modport sink   (input valid, cash, skip, error_in, last, output ready);
endinterface

### sv/npv_out_if.sv
// ----------------------------------------------------------------------------
// npv_out_if: result channel
// Valid/ready channel carrying one net present value word.
// ----------------------------------------------------------------------------
interface npv_out_if;
    import npv_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [SUM_W-1:0] npv;
    logic [STAT_W-1:0]       status;
    logic [ERR_W-1:0]        error_out;

    modport source (output valid, npv, status, error_out, input ready);
    modport sink   (input valid, npv, status, error_out, output ready);
endinterface

### sv/npv_cfg_if.sv
// ----------------------------------------------------------------------------
// npv_cfg_if: configuration write channel
// Valid/ready channel carrying the per-period rate word.
// ----------------------------------------------------------------------------
interface npv_cfg_if;
    import npv_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [RATE_W-1:0] period_rate;

    modport source (output valid, period_rate, input ready);
    modport sink   (input valid, period_rate, output ready);
endinterface

### sv/net_present_value_stream.sv
// ----------------------------------------------------------------------------
// net_present_value_stream: streaming net present value
// A consumed flow runs a 72-step divide through the shared 65-bit adder, a
// 32-step discount multiply and sign steps; no new word is taken until the
// block is idle again. Skipped, erroneous or ignored words go straight to
// the finish state. A last flow skips the multiply and waits there until the
// output register takes its result. Reset clears the rate, sum and faults.
// ----------------------------------------------------------------------------
module net_present_value_stream (
    input  logic    i_clk,
    input  logic    i_rst_n,
    npv_in_if.sink  i_in,
    npv_cfg_if.sink i_cfg,
    npv_out_if.source o_out
);
    import npv_pkg::*;

    logic signed [RATE_W-1:0] r_rate;
    logic                     r_ovalid;
    t_npv_res                 r_ores;
    logic                     res_valid;
    logic                     res_ready;
    t_npv_res                 res;

    npv_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_rate      (r_rate),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res)
    );

    assign i_cfg.ready = 1'b1;
    assign res_ready   = !r_ovalid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_rate <= i_cfg.period_rate;
            end
            if (res_valid && res_ready) begin
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_ready) begin
            r_ores <= res;
        end
    end

    assign o_out.valid     = r_ovalid;
    assign o_out.npv       = r_ores.npv;
    assign o_out.status    = r_ores.status;
    assign o_out.error_out = r_ores.error_out;
endmodule

### sv/npv_alu.sv
// ----------------------------------------------------------------------------
// npv_alu: shared adder/subtractor
// 65-bit add or subtract used for negation, division, summing and multiply.
// ----------------------------------------------------------------------------
module npv_alu (
    input  npv_pkg::t_alu_req           i_req,
    output logic [npv_pkg::ALU_W-1:0]   o_y
);
    import npv_pkg::*;

    assign o_y = i_req.a + (i_req.b ^ {ALU_W{i_req.sub}}) + ALU_W'(i_req.sub);
endmodule

### sv/npv_core.sv
// ----------------------------------------------------------------------------
// npv_core: sequencer and datapath
// Runs divide, sum and discount update of each flow through the shared adder.
// ----------------------------------------------------------------------------
module npv_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    npv_in_if.sink                           i_in,
    input  logic signed [npv_pkg::RATE_W-1:0] i_rate,
    output logic                             o_res_valid,
    input  logic                             i_res_ready,
    output npv_pkg::t_npv_res                o_res
);
    import npv_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE = 10'b00_0000_0001,
        S_NEGC = 10'b00_0000_0010,
        S_NEGD = 10'b00_0000_0100,
        S_DIV  = 10'b00_0000_1000,
        S_NEGQ = 10'b00_0001_0000,
        S_ADD  = 10'b00_0010_0000,
        S_NEGG = 10'b00_0100_0000,
        S_MUL  = 10'b00_1000_0000,
        S_NEGR = 10'b01_0000_0000,
        S_FIN  = 10'b10_0000_0000
    } t_state;

    t_state                r_state, n_state;
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic                  r_last, n_last;
    logic                  r_cneg, n_cneg;
    logic                  r_series, n_series;
    logic [STAT_W-1:0]     r_fault, n_fault;
    logic [ERR_W-1:0]      r_code, n_code;
    logic [DVD_W-1:0]      r_dq, n_dq;
    logic [SUM_W-1:0]      r_rem, n_rem;
    logic [SUM_W-1:0]      r_dmag, n_dmag;
    logic [SUM_W-1:0]      r_disc, n_disc;
    logic [SUM_W-1:0]      r_acc, n_acc;
    logic [SUM_W-1:0]      r_sum, n_sum;

    t_alu_req              alu_req;
    logic [ALU_W-1:0]      alu_y;
    logic [RATE_W:0]       rpo;
    logic [SUM_W-1:0]      rem_s;
    logic [PROD_W-1:0]     prod;
    logic                  qneg;
    logic                  q_ovf;
    logic                  mneg;

    npv_alu u_alu (
        .i_req (alu_req),
        .o_y   (alu_y)
    );

    assign rpo   = {i_rate[RATE_W-1], i_rate} + Q24_ONE;
    assign rem_s = {r_rem[SUM_W-2:0], r_dq[DVD_W-1]};
    assign prod  = {r_rem, r_dq[RATE_W-1:0]};
    assign qneg  = r_cneg ^ r_disc[SUM_W-1];
    assign mneg  = r_disc[SUM_W-1] ^ rpo[RATE_W];
    assign q_ovf = (|r_dq[DVD_W-1:SUM_W])
                 || (r_dq[SUM_W-1] && ((|r_dq[SUM_W-2:0]) || !qneg));

    assign i_in.ready  = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_FIN) && r_last;

    always_comb begin
        o_res.npv       = (r_fault == ST_OK) ? r_sum : '0;
        o_res.status    = r_fault;
        o_res.error_out = (r_fault == ST_INPUT_ERR) ? r_code : '0;
    end

    always_comb begin
        alu_req = '0;
        unique case (r_state)
            S_NEGC: begin
                alu_req.b   = {{(ALU_W-CASH_W){r_dq[DVD_W-1]}}, r_dq[DVD_W-1:FRAC_W]};
                alu_req.sub = 1'b1;
            end
            S_NEGD: begin
                alu_req.b   = {r_disc[SUM_W-1], r_disc};
                alu_req.sub = 1'b1;
            end
            S_DIV: begin
                alu_req.a   = {1'b0, rem_s};
                alu_req.b   = {1'b0, r_dmag};
                alu_req.sub = 1'b1;
            end
            S_NEGQ: begin
                alu_req.b   = {1'b0, r_dq[SUM_W-1:0]};
                alu_req.sub = 1'b1;
            end
            S_ADD: begin
                alu_req.a = {r_sum[SUM_W-1], r_sum};
                alu_req.b = {r_acc[SUM_W-1], r_acc};
            end
            S_NEGG: begin
                alu_req.b   = {{(ALU_W-RATE_W-1){rpo[RATE_W]}}, rpo};
                alu_req.sub = 1'b1;
            end
            S_MUL: begin
                alu_req.a = {1'b0, r_rem};
                alu_req.b = r_dq[0] ? {1'b0, r_dmag} : '0;
            end
            S_NEGR: begin
                alu_req.b   = {2'b00, prod[SUM_W+FRAC_W-2:FRAC_W]};
                alu_req.sub = 1'b1;
            end
            default: alu_req = '0;
        endcase
    end

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_last   = r_last;
        n_cneg   = r_cneg;
        n_series = r_series;
        n_fault  = r_fault;
        n_code   = r_code;
        n_dq     = r_dq;
        n_rem    = r_rem;
        n_dmag   = r_dmag;
        n_disc   = r_disc;
        n_acc    = r_acc;
        n_sum    = r_sum;
        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_last = i_in.last;
                    if (r_fault != ST_OK || i_in.error_in != '0 || i_in.skip) begin
                        if (r_fault == ST_OK && i_in.error_in != '0) begin
                            n_fault = ST_INPUT_ERR;
                            n_code  = i_in.error_in;
                        end
                        n_state = S_FIN;
                    end else begin
                        n_dq   = {i_in.cash, FRAC_W'(0)};
                        n_cneg = i_in.cash[CASH_W-1];
                        if (!r_series) begin
                            n_disc   = {{(SUM_W-RATE_W-1){rpo[RATE_W]}}, rpo};
                            n_series = 1'b1;
                        end
                        n_state = S_NEGC;
                    end
                end
            end
            S_NEGC: begin
                if (r_cneg) begin
                    n_dq[DVD_W-1:FRAC_W] = alu_y[CASH_W-1:0];
                end
                n_state = S_NEGD;
            end
            S_NEGD: begin
                if (r_disc == '0) begin
                    n_fault = ST_NUMERIC_ERR;
                    n_state = S_FIN;
                end else begin
                    n_dmag  = r_disc[SUM_W-1] ? alu_y[SUM_W-1:0] : r_disc;
                    n_rem   = '0;
                    n_cnt   = DIV_LAST;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                n_rem = alu_y[ALU_W-1] ? rem_s : alu_y[SUM_W-1:0];
                n_dq  = {r_dq[DVD_W-2:0], !alu_y[ALU_W-1]};
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_state = S_NEGQ;
                end
            end
            S_NEGQ: begin
                if (q_ovf) begin
                    n_fault = ST_NUMERIC_ERR;
                    n_state = S_FIN;
                end else begin
                    n_acc   = qneg ? alu_y[SUM_W-1:0] : r_dq[SUM_W-1:0];
                    n_state = S_ADD;
                end
            end
            S_ADD: begin
                if (alu_y[ALU_W-1] != alu_y[SUM_W-1]) begin
                    n_fault = ST_NUMERIC_ERR;
                    n_state = S_FIN;
                end else begin
                    n_sum   = alu_y[SUM_W-1:0];
                    n_state = r_last ? S_FIN : S_NEGG;
                end
            end
            S_NEGG: begin
                n_dq[RATE_W-1:0] = rpo[RATE_W] ? alu_y[RATE_W-1:0] : rpo[RATE_W-1:0];
                n_rem   = '0;
                n_cnt   = MUL_LAST;
                n_state = S_MUL;
            end
            S_MUL: begin
                n_rem            = alu_y[ALU_W-1:1];
                n_dq[RATE_W-1:0] = {alu_y[0], r_dq[RATE_W-1:1]};
                n_cnt            = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_state = S_NEGR;
                end
            end
            S_NEGR: begin
                if (|prod[PROD_W-1:SUM_W+FRAC_W-1]) begin
                    n_fault = ST_NUMERIC_ERR;
                end else begin
                    n_disc = mneg ? alu_y[SUM_W-1:0]
                                  : {1'b0, prod[SUM_W+FRAC_W-2:FRAC_W]};
                end
                n_state = S_FIN;
            end
            S_FIN: begin
                if (!r_last) begin
                    n_state = S_IDLE;
                end else if (i_res_ready) begin
                    n_sum    = '0;
                    n_fault  = ST_OK;
                    n_code   = '0;
                    n_series = 1'b0;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_last   <= 1'b0;
            r_series <= 1'b0;
            r_fault  <= ST_OK;
            r_code   <= '0;
            r_sum    <= '0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_last   <= n_last;
            r_series <= n_series;
            r_fault  <= n_fault;
            r_code   <= n_code;
            r_sum    <= n_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cneg <= n_cneg;
        r_dq   <= n_dq;
        r_rem  <= n_rem;
        r_dmag <= n_dmag;
        r_disc <= n_disc;
        r_acc  <= n_acc;
    end
endmodule

### bench/tb_net_present_value_stream.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_net_present_value_stream: self-checking bench for the NPV stream block
// Drives cash flow words in random bursts and stalls the result side on a
// shifting pattern. A bit-accurate scoreboard tracks sum, discount and faults
// and checks each result word in order. Directed series cover the fault
// paths, then random series run under a sequence of rate settings.
// ----------------------------------------------------------------------------
module tb_net_present_value_stream;
    import npv_pkg::*;

    localparam int CLK_PERIOD    = 10;
    localparam int SETTLE_CYCLES = 120;
    localparam int DRAIN_LIMIT   = 5000;
    localparam int RAND_PHASES   = 10;
    localparam int PHASE_FLOWS   = 115;

    localparam logic [CASH_W-1:0] CASH_MAX = {1'b0, {(CASH_W-1){1'b1}}};
    localparam logic [CASH_W-1:0] CASH_MIN = {1'b1, {(CASH_W-1){1'b0}}};

    localparam logic [RATE_W-1:0] RATE_ZERO_DISC  = 32'hFF00_0000;
    localparam logic [RATE_W-1:0] RATE_TINY_DISC  = 32'hFF00_0001;
    localparam logic [RATE_W-1:0] RATE_FAST_DECAY = 32'hFF00_1000;
    localparam logic [RATE_W-1:0] RATE_MAX        = 32'h7FFF_FFFF;
    localparam logic [RATE_W-1:0] RATE_MIN        = 32'h8000_0000;
    localparam logic [RATE_W-1:0] RATE_HALF       = 32'h0080_0000;

    typedef struct packed {
        logic [CASH_W-1:0] cash;
        logic              skip;
        logic [ERR_W-1:0]  err;
        logic              last;
    } t_flow_word;

    logic i_clk = 1'b0;
    logic i_rst_n;

    npv_in_if  in_if ();
    npv_cfg_if cfg_if ();
    npv_out_if out_if ();

    net_present_value_stream u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .i_cfg   (cfg_if),
        .o_out   (out_if)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    t_flow_word flow_queue[$];
    t_npv_res   npv_expected[$];

    logic [RATE_W-1:0] rate_reg;
    logic [SUM_W-1:0]  acc_sum;
    logic [SUM_W-1:0]  acc_disc;
    logic [STAT_W-1:0] fault_st;
    logic [ERR_W-1:0]  fault_err;
    logic              series_open;

    int mismatch_count = 0;
    int words_total    = 0;
    int words_skipped  = 0;
    int words_flagged  = 0;
    int res_ok         = 0;
    int res_in_err     = 0;
    int res_num_err    = 0;
    int rates_used     = 0;

    function automatic logic [SUM_W-1:0] growth(input logic [RATE_W-1:0] r);
        return {{(SUM_W-RATE_W){r[RATE_W-1]}}, r} + (64'(1) << FRAC_W);
    endfunction

    function automatic logic [SUM_W-1:0] scale_discount(input logic [SUM_W-1:0] d,
                                                        input logic [SUM_W-1:0] g,
                                                        output logic ok);
        logic [SUM_W-1:0]   dm;
        logic [SUM_W-1:0]   gm;
        logic [SUM_W-1:0]   m;
        logic [2*SUM_W-1:0] prod;
        dm   = d[SUM_W-1] ? -d : d;
        gm   = g[SUM_W-1] ? -g : g;
        prod = {64'b0, dm} * {64'b0, gm};
        ok   = (prod[2*SUM_W-1:SUM_W+FRAC_W-1] == '0);
        m    = prod[SUM_W+FRAC_W-1:FRAC_W];
        return (d[SUM_W-1] ^ g[SUM_W-1]) ? -m : m;
    endfunction

    function automatic logic [SUM_W-1:0] flow_term(input logic [CASH_W-1:0] cash,
                                                   input logic [SUM_W-1:0] disc,
                                                   output logic bad);
        logic [SUM_W-1:0] c;
        logic [SUM_W-1:0] cm;
        logic [SUM_W-1:0] dm;
        logic [DVD_W-1:0] q;
        logic [DVD_W-1:0] lim;
        logic             neg;
        c   = {{(SUM_W-CASH_W){cash[CASH_W-1]}}, cash};
        cm  = c[SUM_W-1] ? -c : c;
        dm  = disc[SUM_W-1] ? -disc : disc;
        neg = c[SUM_W-1] ^ disc[SUM_W-1];
        q   = (DVD_W'(cm) << FRAC_W) / DVD_W'(dm);
        lim = DVD_W'(1) << (SUM_W - 1);
        bad = (q > lim) || (!neg && q == lim);
        return neg ? -q[SUM_W-1:0] : q[SUM_W-1:0];
    endfunction

    task automatic absorb_flow(input logic [CASH_W-1:0] cash);
        logic [SUM_W-1:0] term;
        logic [SUM_W-1:0] s;
        logic             bad;
        if (!series_open) begin
            acc_disc    = growth(rate_reg);
            series_open = 1'b1;
        end
        if (acc_disc == '0) begin
            fault_st = ST_NUMERIC_ERR;
            return;
        end
        term = flow_term(cash, acc_disc, bad);
        if (bad) begin
            fault_st = ST_NUMERIC_ERR;
            return;
        end
        s = acc_sum + term;
        if (acc_sum[SUM_W-1] == term[SUM_W-1] && s[SUM_W-1] != term[SUM_W-1])
            fault_st = ST_NUMERIC_ERR;
        else
            acc_sum = s;
    endtask

    task automatic clear_series();
        acc_sum     = '0;
        acc_disc    = growth(rate_reg);
        fault_st    = ST_OK;
        fault_err   = '0;
        series_open = 1'b0;
    endtask

    task automatic predict_npv(input t_flow_word w);
        t_npv_res         r;
        logic [SUM_W-1:0] nd;
        logic             ok;
        if (fault_st == ST_OK) begin
            if (w.err != '0) begin
                fault_st  = ST_INPUT_ERR;
                fault_err = w.err;
            end else if (!w.skip) begin
                absorb_flow(w.cash);
                if (fault_st == ST_OK && !w.last) begin
                    nd = scale_discount(acc_disc, growth(rate_reg), ok);
                    if (ok)
                        acc_disc = nd;
                    else
                        fault_st = ST_NUMERIC_ERR;
                end
            end
        end
        if (w.last) begin
            r.npv       = (fault_st == ST_OK) ? acc_sum : '0;
            r.status    = fault_st;
            r.error_out = (fault_st == ST_INPUT_ERR) ? fault_err : '0;
            npv_expected.push_back(r);
            clear_series();
        end
    endtask

    task automatic report_mismatch(input string what, input t_npv_res exp_r,
                                   input t_npv_res got_r);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("[%0t] %s: expected npv=%0d status=%0d err=%0d, got npv=%0d status=%0d err=%0d",
                     $realtime, what, $signed(exp_r.npv), exp_r.status, exp_r.error_out,
                     $signed(got_r.npv), got_r.status, got_r.error_out);
    endtask

    // Scoreboard: check results, track the rate, predict accepted words
    always @(posedge i_clk) begin
        t_npv_res got_r;
        t_npv_res exp_r;
        t_flow_word w;
        if (!i_rst_n) begin
            rate_reg = '0;
            clear_series();
        end else begin
            if (out_if.valid && out_if.ready) begin
                got_r.npv       = out_if.npv;
                got_r.status    = out_if.status;
                got_r.error_out = out_if.error_out;
                case (got_r.status)
                    ST_OK:        res_ok++;
                    ST_INPUT_ERR: res_in_err++;
                    default:      res_num_err++;
                endcase
                if (npv_expected.size() == 0) begin
                    report_mismatch("unexpected result", '0, got_r);
                end else begin
                    exp_r = npv_expected.pop_front();
                    if (got_r.npv !== exp_r.npv || got_r.status !== exp_r.status ||
                        got_r.error_out !== exp_r.error_out)
                        report_mismatch("result mismatch", exp_r, got_r);
                end
            end
            if (cfg_if.valid && cfg_if.ready)
                rate_reg = cfg_if.period_rate;
            if (in_if.valid && in_if.ready) begin
                w.cash = in_if.cash;
                w.skip = in_if.skip;
                w.err  = in_if.error_in;
                w.last = in_if.last;
                words_total++;
                if (w.skip) words_skipped++;
                if (w.err != '0) words_flagged++;
                predict_npv(w);
            end
        end
    end

    // Driver: send queued words in bursts separated by gaps
    int burst_left = 1;
    int gap_left   = 0;

    always @(posedge i_clk) begin
        t_flow_word w;
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else if (!in_if.valid || in_if.ready) begin
            if (gap_left != 0 || flow_queue.size() == 0) begin
                in_if.valid <= 1'b0;
                if (gap_left != 0) gap_left--;
            end else begin
                w = flow_queue.pop_front();
                in_if.valid    <= 1'b1;
                in_if.cash     <= w.cash;
                in_if.skip     <= w.skip;
                in_if.error_in <= w.err;
                in_if.last     <= w.last;
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                             : $urandom_range(1, 8);
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3, 4, 5, 6: gap_left = $urandom_range(0, 3);
                        7, 8:                gap_left = $urandom_range(0, 20);
                        default:             gap_left = $urandom_range(0, 130);
                    endcase
                end
            end
        end
    end

    // Receiver: drive ready from a random pattern reloaded whenever the 6-bit phase counter wraps
    logic [5:0]  stall_phase = '0;
    logic [31:0] stall_pattern = '1;

    always @(posedge i_clk) begin
        if (stall_phase == '0)
            stall_pattern = ($urandom_range(0, 3) == 0) ? '1 : $urandom;
        out_if.ready <= stall_pattern[stall_phase[4:0]];
        stall_phase = stall_phase + 1'b1;
    end

    function automatic logic [CASH_W-1:0] rand_cash();
        case ($urandom_range(0, 9))
            0:       return CASH_MAX;
            1:       return CASH_MIN;
            2:       return '0;
            3, 4, 5: return CASH_W'($urandom_range(0, 32'h20_0000)) - 48'h10_0000;
            default: return {16'($urandom), 32'($urandom)};
        endcase
    endfunction

    function automatic logic [RATE_W-1:0] pick_rate();
        case ($urandom_range(0, 9))
            0:       return RATE_MAX;
            1:       return RATE_MIN;
            2:       return $urandom;
            3:       return '0;
            default: return RATE_W'($urandom_range(0, 32'h40_0000)) - 32'h20_0000;
        endcase
    endfunction

    task automatic add_word(input logic [CASH_W-1:0] cash, input logic skip,
                            input logic [ERR_W-1:0] err, input logic last);
        t_flow_word w;
        w.cash = cash;
        w.skip = skip;
        w.err  = err;
        w.last = last;
        flow_queue.push_back(w);
    endtask

    task automatic settle();
        do @(posedge i_clk);
        while (flow_queue.size() != 0 || in_if.valid || npv_expected.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_rate(input logic [RATE_W-1:0] value);
        settle();
        cfg_if.period_rate <= value;
        cfg_if.valid       <= 1'b1;
        do @(posedge i_clk);
        while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        rates_used++;
    endtask

    initial begin
        int   len;
        int   consumed;
        int   waited;
        logic skip;
        logic [ERR_W-1:0] err;

        i_rst_n            = 1'b0;
        in_if.valid        = 1'b0;
        in_if.cash         = '0;
        in_if.skip         = 1'b0;
        in_if.error_in     = '0;
        in_if.last         = 1'b0;
        cfg_if.valid       = 1'b0;
        cfg_if.period_rate = '0;
        out_if.ready       = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset rate: extremes, skip, error precedence, first fault kept, empty series
        add_word(CASH_MAX, 1'b0, 4'h0, 1'b0);
        add_word(CASH_MIN, 1'b0, 4'h0, 1'b0);
        add_word(rand_cash(), 1'b1, 4'h0, 1'b0);
        add_word('0, 1'b0, 4'h0, 1'b1);
        add_word(48'h5_0000, 1'b0, 4'h0, 1'b1);
        add_word(rand_cash(), 1'b1, 4'hF, 1'b0);
        add_word(rand_cash(), 1'b0, 4'h0, 1'b0);
        add_word(rand_cash(), 1'b0, 4'h3, 1'b1);
        add_word(rand_cash(), 1'b1, 4'h0, 1'b1);

        // Zero starting discount
        write_rate(RATE_ZERO_DISC);
        add_word(CASH_MAX, 1'b0, 4'h0, 1'b1);

        // Discount truncates to zero on the second flow
        write_rate(RATE_TINY_DISC);
        add_word(48'h1, 1'b0, 4'h0, 1'b0);
        add_word(48'h1, 1'b0, 4'h0, 1'b1);

        // Sum overflow, then term overflow
        write_rate(RATE_FAST_DECAY);
        add_word(CASH_MAX, 1'b0, 4'h0, 1'b0);
        add_word((48'h1 << 39) - 48'h1, 1'b0, 4'h0, 1'b1);
        add_word(CASH_MAX, 1'b0, 4'h0, 1'b0);
        add_word(CASH_MAX, 1'b0, 4'h0, 1'b1);

        // Discount overflow under the largest rate
        write_rate(RATE_MAX);
        repeat (5) add_word(rand_cash(), 1'b0, 4'h0, 1'b0);
        add_word(rand_cash(), 1'b0, 4'h0, 1'b1);

        // Negative discount, then change the rate mid-series
        write_rate(RATE_MIN);
        add_word(rand_cash(), 1'b0, 4'h0, 1'b0);
        add_word(rand_cash(), 1'b0, 4'h0, 1'b0);
        write_rate(RATE_HALF);
        add_word(rand_cash(), 1'b0, 4'h0, 1'b1);

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            write_rate(pick_rate());
            consumed = 0;
            while (consumed < PHASE_FLOWS) begin
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40)
                                                  : $urandom_range(1, 12);
                for (int k = 0; k < len && consumed < PHASE_FLOWS; k++) begin
                    skip = ($urandom_range(0, 9) == 0);
                    err  = ($urandom_range(0, 29) == 0) ? ERR_W'($urandom_range(1, 15)) : '0;
                    add_word(rand_cash(), skip, err, k == len - 1);
                    if (!skip) consumed++;
                end
            end
        end

        do @(posedge i_clk);
        while (flow_queue.size() != 0 || in_if.valid);
        waited = 0;
        while (npv_expected.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (npv_expected.size() != 0) begin
            $display("%0d expected results never arrived", npv_expected.size());
            mismatch_count += npv_expected.size();
        end

        $display("Sent %0d cash flow words (%0d skipped, %0d error-marked) under %0d rate settings",
                 words_total, words_skipped, words_flagged, rates_used);
        $display("Checked %0d results: %0d ok, %0d input error, %0d numeric error; %0d mismatches",
                 res_ok + res_in_err + res_num_err, res_ok, res_in_err, res_num_err,
                 mismatch_count);
        if (mismatch_count == 0)
            $display("** net_present_value_stream: PASSED **");
        else
            $display("** net_present_value_stream: FAILED **");
        $finish;
    end

    initial begin
        #20ms;
        $display("Timeout: %0d words queued, %0d results outstanding",
                 flow_queue.size(), npv_expected.size());
        $display("** net_present_value_stream: FAILED **");
        $finish;
    end

endmodule
